>>> rtl/best_parent_subset_dp_defines.svh
// Assertion macros shared by the best_parent_subset_dp RTL.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef BEST_PARENT_SUBSET_DP_DEFINES_SVH
`define BEST_PARENT_SUBSET_DP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpsd_pkg.sv
// Package for the best parent set block: field widths, register indexes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

  localparam int MASK_W    = 12;
  localparam int SCORE_W   = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int BIT_W     = $clog2(MASK_W);

  localparam int IN_DATA_W  = 48;  // mask + score, padded to bytes
  localparam int OUT_DATA_W = 56;  // mask + score + set

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARENTS = 1'b1;

  localparam logic [CFG_W-1:0] NUM_VARS_RST    = 4'd12;
  localparam logic [CFG_W-1:0] MAX_PARENTS_RST = 4'd12;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [MASK_W-1:0]         mask_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture input item, set up scan
    logic scan;    // visit one bit position, issue predecessor read
    logic finish;  // resolve result, write tables
    logic push;    // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_bit;  // scan sits on bit zero
    logic out_free;  // output register can take a result
  } status_t;

endpackage

`default_nettype wire

>>> rtl/bpsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpsd_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpsd_ctrl.sv
// Controller FSM for the best parent set block: input handshake and
// sequencing of scan, drain, finish and output push. Uses bpsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "best_parent_subset_dp_defines.svh"

module bpsd_ctrl
  import bpsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.last_bit) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data lands this cycle
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        cmd_o.push   = st_i.out_free;
        state_d      = st_i.out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        cmd_o.push = st_i.out_free;
        if (st_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BPSD_ASSERT_NEXT(a_accept_starts_scan, in_valid_i && in_ready_o, state_q == ST_SCAN, "accept did not start scan")
  `BPSD_ASSERT_IMPL(a_push_needs_room, cmd_o.push, st_i.out_free, "push while output busy")
  `BPSD_ASSERT_NEXT(a_scan_ends, state_q == ST_SCAN && st_i.last_bit, state_q == ST_DRAIN, "scan did not end on bit zero")

endmodule

`default_nettype wire

>>> rtl/bpsd_dp.sv
// Datapath for the best parent set block: mask trim, bit scan, table RAM,
// running maximum, final choice and output register. Uses bpsd_pkg, bpsd_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "best_parent_subset_dp_defines.svh"

module bpsd_dp
  import bpsd_pkg::*;
#(
  parameter int MAX_VARS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               st_o,
  input  wire logic [CFG_W-1:0] num_vars_i,
  input  wire logic [CFG_W-1:0] max_parents_i,
  input  wire mask_t            mask_i,
  input  wire score_t           local_score_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output mask_t                 out_mask_o,
  output score_t                best_score_o,
  output mask_t                 best_set_o
);

  localparam int AW    = MAX_VARS;
  localparam int DEPTH = 2 ** MAX_VARS;
  localparam int DW    = MASK_W + SCORE_W;
  localparam logic [CFG_W:0] MAXV = (CFG_W + 1)'(MAX_VARS);
  localparam logic [CFG_W:0] ONE  = (CFG_W + 1)'(1);

  mask_t            mask_q;
  score_t           ls_q;
  logic [BIT_W-1:0] bit_q;
  logic [BIT_W-1:0] pc_q;
  score_t           best_q;
  mask_t            bset_q;
  logic             have_q;
  logic             rd_vld_q;
  logic             out_vld_q;

  logic [CFG_W:0]   eff_nv;
  mask_t            low_mask;
  logic [BIT_W-1:0] top_bit;

  logic             re;
  logic [AW-1:0]    raddr;
  logic [DW-1:0]    rdata;
  score_t           rd_score;
  mask_t            rd_set;
  logic             take;

  score_t           fin_score;
  mask_t            fin_set;

  // Clamp variable count to [1, MAX_VARS], build trim mask and scan start.
  always_comb begin
    eff_nv = {1'b0, num_vars_i};
    if (eff_nv == '0) begin
      eff_nv = ONE;
    end else if (eff_nv > MAXV) begin
      eff_nv = MAXV;
    end
    for (int i = 0; i < MASK_W; i++) begin
      low_mask[i] = eff_nv > (CFG_W + 1)'(i);
    end
    if (eff_nv >= (CFG_W + 1)'(MASK_W)) begin
      top_bit = BIT_W'(MASK_W - 1);
    end else begin
      top_bit = BIT_W'(eff_nv - ONE);
    end
  end

  // Predecessor read: current mask with the scanned bit cleared.
  assign re    = cmd_i.scan && mask_q[bit_q];
  assign raddr = AW'(mask_q & ~(MASK_W'(1) << bit_q));

  assign rd_score = score_t'(rdata[SCORE_W-1:0]);
  assign rd_set   = rdata[DW-1:SCORE_W];
  // strict compare keeps the earlier candidate on a tie
  assign take     = rd_vld_q && (!have_q || (best_q < rd_score));

  always_comb begin
    fin_score = best_q;
    fin_set   = bset_q;
    if (mask_q == '0) begin
      fin_score = ls_q;
      fin_set   = '0;
    end else if ((pc_q <= max_parents_i) && (best_q < ls_q)) begin
      fin_score = ls_q;
      fin_set   = mask_q;
    end
  end

  bpsd_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.finish),
    .waddr_i(AW'(mask_q)),
    .wdata_i({fin_set, fin_score}),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      rd_vld_q <= re;
      if (cmd_i.load) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_q <= mask_i & low_mask;
      ls_q   <= local_score_i;
      bit_q  <= top_bit;
      pc_q   <= '0;
    end
    if (cmd_i.scan) begin
      bit_q <= bit_q - BIT_W'(1);
      pc_q  <= pc_q + BIT_W'(mask_q[bit_q]);
    end
    if (cmd_i.finish) begin
      best_q <= fin_score;
      bset_q <= fin_set;
    end else if (take) begin
      best_q <= rd_score;
      bset_q <= rd_set;
    end
    if (cmd_i.push) begin
      out_mask_o   <= mask_q;
      best_score_o <= cmd_i.finish ? fin_score : best_q;
      best_set_o   <= cmd_i.finish ? fin_set : bset_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign st_o.last_bit = (bit_q == '0);
  assign st_o.out_free = !out_vld_q || out_ready_i;

  `BPSD_ASSERT_IMPL(a_no_read_in_flight, cmd_i.finish, !rd_vld_q && !re, "read pending at finish")
  `BPSD_ASSERT_IMPL(a_popcount_done, cmd_i.finish, pc_q == BIT_W'($countones(mask_q)), "scan missed a bit")
  `BPSD_ASSERT_NEXT(a_push_shows, cmd_i.push, out_valid_o, "pushed result not presented")

endmodule

`default_nettype wire

>>> rtl/best_parent_subset_dp.sv
// Best parent set block: one result per candidate mask, built from stored
// results of the one-bit-smaller masks. Uses bpsd_pkg, bpsd_ctrl, bpsd_dp.
//
// Usage:
//   s_axis: one transfer per candidate mask, masks in ascending order from 0.
//   m_axis: one transfer per input, carrying the trimmed mask, the best score
//           over all its subsets and the subset that reaches it.
//   cfg:    register writes (index 0 num_vars, index 1 max_parents); always
//           ready, only to be used while the block is idle.
// Sequencing, with n = min(clamped num_vars, 12): an accepted item scans
//   bits n-1 down to zero, then drains, finishes and pushes its result; no
//   new item is taken before that push. The bit scan visits one bit per cycle
//   and issues a predecessor read for each set bit on the single table read port.
// Reset: both registers return to 12, the controller idles, the output is
//   empty. The score/set table is not cleared; entries are written before
//   they are read as long as masks arrive in ascending order.
// Stall: a finished result waits in the datapath until the output register
//   frees; no new item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module best_parent_subset_dp
  import bpsd_pkg::*;
#(
  parameter int MAX_VARS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream: [11:0] mask, [43:12] local_score, [47:44] zero
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // output stream: [11:0] out_mask, [43:12] best_score, [55:44] best_set
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  logic [CFG_W-1:0] num_vars_q;
  logic [CFG_W-1:0] max_parents_q;

  cmd_t    cmd;
  status_t st;

  mask_t   out_mask;
  score_t  best_score;
  mask_t   best_set;

  // Configuration registers; always ready, a write transfer is registered directly.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q    <= NUM_VARS_RST;
      max_parents_q <= MAX_PARENTS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_VARS:    num_vars_q    <= cfg_data_i;
        CFG_MAX_PARENTS: max_parents_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpsd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  bpsd_dp #(
    .MAX_VARS(MAX_VARS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .num_vars_i   (num_vars_q),
    .max_parents_i(max_parents_q),
    .mask_i       (s_axis_tdata[MASK_W-1:0]),
    .local_score_i(score_t'(s_axis_tdata[MASK_W+SCORE_W-1:MASK_W])),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_mask_o   (out_mask),
    .best_score_o (best_score),
    .best_set_o   (best_set)
  );

  assign m_axis_tdata = {best_set, best_score, out_mask};

endmodule

`default_nettype wire

>>> verif/best_parent_subset_dp_test.sv
// Self-checking bench for best_parent_subset_dp: a directed table of masks and
// register writes, then random ascending mask sweeps under many settings.
// Depends on bpsd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module best_parent_subset_dp_test;
  import bpsd_pkg::*;

  localparam int     TBL_DEPTH    = 1 << MASK_W;
  localparam int     QUIET_LIMIT  = 3000;  // cycles with no transfer on any channel
  localparam int     RANDOM_ITEMS = 750;
  localparam int     TAIL_CYCLES  = 40;
  localparam score_t SCORE_MIN    = score_t'(32'h8000_0000);
  localparam score_t SCORE_MAX    = score_t'(32'h7fff_ffff);

  typedef struct {
    mask_t  out_mask;
    score_t best_score;
    mask_t  best_set;
  } best_entry_t;

  // one row of the directed table: a register write or an input item
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    mask_t                in_mask;
    score_t               in_score;
    bit                   typed;   // want holds a hand-written result
    best_entry_t          want;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  // bench copy of the registers and of the best-subset tables
  logic [CFG_W-1:0] nv_reg = NUM_VARS_RST;
  logic [CFG_W-1:0] mp_reg = MAX_PARENTS_RST;
  score_t           dp_score [TBL_DEPTH];
  mask_t            dp_set   [TBL_DEPTH];
  bit               dp_seen  [TBL_DEPTH];

  best_entry_t pending_best [$];
  stim_row_t   dir_rows [$];
  int          err_count    = 0;
  int          quiet_cycles = 0;
  int          src_calm     = 0;  // items left in a no-gap stretch, sender side
  int          sink_calm    = 0;  // same on the receiving side

  best_parent_subset_dp dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,   // [11:0] mask, [43:12] local_score, [47:44] zero
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,   // [11:0] out_mask, [43:12] best_score, [55:44] best_set
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // num_vars clamped to 1..MASK_W
  function automatic int active_vars();
    int n;
    n = nv_reg;
    if (n < 1) n = 1;
    if (n > MASK_W) n = MASK_W;
    return n;
  endfunction

  function automatic mask_t var_mask();
    return mask_t'((1 << active_vars()) - 1);
  endfunction

  // every one-bit-smaller subset already has a table entry
  function automatic bit preds_ready(mask_t m);
    for (int b = 0; b < MASK_W; b++)
      if (m[b] && !dp_seen[m & ~(mask_t'(1) << b)]) return 1'b0;
    return 1'b1;
  endfunction

  // Best subset of a trimmed mask: the best stored one-bit-smaller subset,
  // highest cleared bit first, ties keep the earlier one; the mask itself wins
  // only if small enough and strictly better. Updates the tables.
  function automatic best_entry_t predict_best_parent(mask_t raw, score_t ls);
    best_entry_t r;
    mask_t       m;
    mask_t       pred;
    bit          have;
    m            = raw & var_mask();
    r.out_mask   = m;
    r.best_score = ls;
    r.best_set   = '0;
    if (m != '0) begin
      have = 1'b0;
      for (int b = MASK_W - 1; b >= 0; b--) begin
        if (m[b]) begin
          pred = m & ~(mask_t'(1) << b);
          if (!have || dp_score[pred] > r.best_score) begin
            r.best_score = dp_score[pred];
            r.best_set   = dp_set[pred];
            have         = 1'b1;
          end
        end
      end
      if ($countones(m) <= int'(mp_reg) && ls > r.best_score) begin
        r.best_score = ls;
        r.best_set   = m;
      end
    end
    dp_score[m] = r.best_score;
    dp_set[m]   = r.best_set;
    dp_seen[m]  = 1'b1;
    return r;
  endfunction

  task automatic add_item(mask_t m, score_t ls, bit typed = 1'b0, mask_t em = '0,
                          score_t es = '0, mask_t eset = '0);
    stim_row_t row;
    row.is_reg          = 1'b0;
    row.reg_idx         = '0;
    row.reg_val         = '0;
    row.in_mask         = m;
    row.in_score        = ls;
    row.typed           = typed;
    row.want.out_mask   = em;
    row.want.best_score = es;
    row.want.best_set   = eset;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_NUM_VARS) nv_reg = val;
    else mp_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(mask_t raw, score_t ls, bit typed, best_entry_t want);
    int          gap;
    best_entry_t got;
    gap = (src_calm > 0) ? 0 : $urandom_range(0, 10);
    if (src_calm > 0) src_calm--;
    else if ($urandom_range(0, 24) == 0) src_calm = $urandom_range(10, 40);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({ls, raw});
    do @(posedge clk_i); while (!s_axis_tready);
    got = predict_best_parent(raw, ls);
    pending_best.insert(pending_best.size(), typed ? want : got);
  endtask

  // receiver: random stall before each transfer, with calm stretches
  initial begin : sink_drive
    int gap;
    wait (rst_ni);
    forever begin
      gap = (sink_calm > 0) ? 0 : $urandom_range(0, 10);
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 24) == 0) sink_calm = $urandom_range(10, 40);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // result checker: in order against the oldest pending expectation
  always @(posedge clk_i) begin : result_check
    best_entry_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_best.size() == 0) begin
        $error("unexpected result for mask %0d", m_axis_tdata[MASK_W-1:0]);
        err_count++;
      end else begin
        want = pending_best.pop_front();
        if (m_axis_tdata[MASK_W-1:0] !== want.out_mask) begin
          $error("out_mask: expected %0d, got %0d", want.out_mask,
                 m_axis_tdata[MASK_W-1:0]);
          err_count++;
        end
        if (m_axis_tdata[MASK_W+SCORE_W-1:MASK_W] !== want.best_score) begin
          $error("best_score: expected %0d, got %0d", want.best_score,
                 $signed(m_axis_tdata[MASK_W+SCORE_W-1:MASK_W]));
          err_count++;
        end
        if (m_axis_tdata[2*MASK_W+SCORE_W-1:MASK_W+SCORE_W] !== want.best_set) begin
          $error("best_set: expected %0d, got %0d", want.best_set,
                 m_axis_tdata[2*MASK_W+SCORE_W-1:MASK_W+SCORE_W]);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    int               n_vars;
    int               seq_len;
    int               pos;
    int               sent;
    logic [CFG_W-1:0] nv_pick;
    mask_t            m;
    mask_t            raw;
    mask_t            vm;
    score_t           ls;
    best_entry_t      none;
    none.out_mask   = '0;
    none.best_score = '0;
    none.best_set   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the reset settings (12 vars, 12 parents).
    add_item(12'h000, SCORE_MIN, 1, 12'h000, SCORE_MIN, 12'h000);  // empty set
    add_item(12'h001, SCORE_MAX, 1, 12'h001, SCORE_MAX, 12'h001);
    add_item(12'h002, 0,         1, 12'h002, 0,         12'h002);
    add_item(12'h003, SCORE_MIN, 1, 12'h003, SCORE_MAX, 12'h001);
    add_item(12'h004, 5,         1, 12'h004, 5,         12'h004);
    add_item(12'h005, 32'h1234_5678);
    add_item(12'h006, 5,         1, 12'h006, 5,         12'h004);  // own score only ties
    add_item(12'h007, SCORE_MAX, 1, 12'h007, SCORE_MAX, 12'h001);
    add_item(12'h008, 0,         1, 12'h008, 0,         12'h008);
    add_item(12'h009, -1);
    add_item(12'h00a, -1,        1, 12'h00a, 0,         12'h002);  // subset tie: high bit cleared first wins
    add_item(12'h00b, 32'h0001_0000);
    add_reg(CFG_MAX_PARENTS, 4'd0);                                // own score never wins
    add_item(12'h00c, SCORE_MAX, 1, 12'h00c, 5,         12'h004);
    add_reg(CFG_NUM_VARS, 4'd2);                                   // high mask bits trimmed
    add_item(12'hfff, 3,         1, 12'h003, SCORE_MAX, 12'h001);
    add_item(12'hffe, SCORE_MAX, 1, 12'h002, SCORE_MIN, 12'h000);
    add_reg(CFG_NUM_VARS, 4'd0);                                   // acts as one var
    add_item(12'h003, 1,         1, 12'h001, SCORE_MIN, 12'h000);
    add_reg(CFG_NUM_VARS, 4'd15);                                  // acts as MASK_W
    add_item(12'h800, 1,         1, 12'h800, SCORE_MIN, 12'h000);
    add_reg(CFG_MAX_PARENTS, 4'd15);                               // above num_vars
    add_item(12'h801, 1,         1, 12'h801, 1,         12'h801);
    add_item(12'h000, SCORE_MAX, 1, 12'h000, SCORE_MAX, 12'h000);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        drain_results();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].in_mask, dir_rows[i].in_score, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    // Random part: each phase picks new settings and sweeps masks upward from
    // zero; a share of items repeats or jumps to any mask whose subsets are
    // already stored, and junk above num_vars rides on half the masks.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 15))
        0:       nv_pick = 4'd0;
        1:       nv_pick = CFG_W'($urandom_range(13, 15));
        2:       nv_pick = 4'd12;
        3:       nv_pick = 4'd1;
        default: nv_pick = CFG_W'($urandom_range(2, 7));
      endcase
      write_reg(CFG_NUM_VARS, nv_pick);
      write_reg(CFG_MAX_PARENTS, CFG_W'($urandom_range(0, 15)));
      n_vars  = active_vars();
      vm      = var_mask();
      seq_len = ((1 << n_vars) <= 80) ? (1 << n_vars) : $urandom_range(20, 80);
      pos     = 0;
      while (pos < seq_len) begin
        if ($urandom_range(0, 6) == 0) begin
          m = mask_t'($urandom) & vm;
          if (!preds_ready(m)) m = mask_t'($urandom_range(0, pos));
        end else begin
          m = mask_t'(pos);
          pos++;
        end
        raw = ($urandom_range(0, 1) == 1) ? (m | (mask_t'($urandom) & ~vm)) : m;
        // small scores make ties between subsets common
        case ($urandom_range(0, 7))
          0:       ls = SCORE_MIN;
          1:       ls = SCORE_MAX;
          2, 3:    ls = score_t'($urandom_range(0, 4)) - 2;
          default: ls = score_t'($urandom);
        endcase
        send_item(raw, ls, 1'b0, none);
        sent++;
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_best.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
